// File: src/display_bus_contention_delay_macros.svh
// Assertion macros shared by the contention delay RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef DISPLAY_BUS_CONTENTION_DELAY_MACROS_SVH
`define DISPLAY_BUS_CONTENTION_DELAY_MACROS_SVH
`ifndef SYNTH
`define DBCD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DBCD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `DBCD_ASSERT(lbl, clk, rst_n, !(cond), msg)
`else
`define DBCD_ASSERT(lbl, clk, rst_n, prop, msg)
`define DBCD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// File: src/dbcd_pkg.sv
// Types, constants and register codes of the contention delay block.
// No dependencies; used by every other file but the macros header.
`default_nettype none
package dbcd_pkg;

  localparam int unsigned TS_W       = 32;
  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned WAIT_W     = 5;
  localparam int unsigned CS_W       = 17;
  localparam int unsigned LL_W       = 10;
  localparam int unsigned NL_W       = 9;
  localparam int unsigned DW_W       = 10;
  localparam int unsigned FL_W       = 17;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned STEP_W     = 3;
  localparam int unsigned RAW_W      = 3;
  localparam int unsigned PROD_W     = NL_W + LL_W;

  // divider: bits retired per cycle and cycle counts
  localparam int unsigned RADIX       = 4;
  localparam int unsigned MOD_CYCLES  = TS_W / RADIX;
  localparam int unsigned DIV_CYCLES  = 5;
  localparam int unsigned DIV_BITS    = DIV_CYCLES * RADIX;
  localparam int unsigned CNT_W       = $clog2(MOD_CYCLES);
  localparam logic [CNT_W-1:0] MOD_LAST = CNT_W'(MOD_CYCLES - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_CYCLES - 1);

  localparam int unsigned PATTERN_PERIOD = 8;
  localparam int unsigned PAT_IDX_W      = $clog2(PATTERN_PERIOD);
  localparam logic [RAW_W-1:0] STALL_PATTERN [PATTERN_PERIOD] =
    '{3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0, 3'd0};

  localparam logic [ADDR_W-1:0] BANK_MASK = 16'hc000;
  localparam logic [ADDR_W-1:0] BANK_BASE = 16'h4000;
  localparam logic [WAIT_W-1:0] MAX_WAIT  = 5'd24;

  localparam logic [CS_W-1:0] RST_CONT_START = 17'd14335;
  localparam logic [LL_W-1:0] RST_LINE_LEN   = 10'd224;
  localparam logic [NL_W-1:0] RST_LINE_COUNT = 9'd192;
  localparam logic [DW_W-1:0] RST_DISP_WIDTH = 10'd128;
  localparam logic [FL_W-1:0] RST_FRAME_LEN  = 17'd69888;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CONT_START = 3'd0,
    REG_LINE_LEN   = 3'd1,
    REG_LINE_COUNT = 3'd2,
    REG_DISP_WIDTH = 3'd3,
    REG_FRAME_LEN  = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    ACT_MEM = 1'b0,
    ACT_IO  = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    RAW_IDLE,
    RAW_MOD,
    RAW_POS,
    RAW_DIV,
    RAW_MUL,
    RAW_COL,
    RAW_DONE
  } raw_state_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_REQ,
    BK_WAIT,
    BK_OUT
  } back_state_e;

  typedef struct packed {
    logic [CS_W-1:0] contention_start;
    logic [LL_W-1:0] line_len;
    logic [NL_W-1:0] display_line_count;
    logic [DW_W-1:0] display_width;
    logic [FL_W-1:0] frame_length;
  } cfg_t;

  // work for the back end: first sample time and number of samples
  typedef struct packed {
    logic [TS_W-1:0]   t0;
    logic [STEP_W-1:0] nsteps;
  } plan_t;

  typedef struct packed {
    logic            start;
    logic [TS_W-1:0] tnow;
  } raw_req_t;

  typedef struct packed {
    logic             done;
    logic [RAW_W-1:0] delay;
  } raw_rsp_t;

endpackage
`default_nettype wire

// File: src/dbcd_if.sv
// Valid/ready channel interfaces for bus access words and delay words.
// Depends on dbcd_pkg for field widths.
`default_nettype none
interface dbcd_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [dbcd_pkg::TS_W-1:0]     tstate_now;
  logic [dbcd_pkg::ADDR_W-1:0]   bus_address;

  modport source (output valid, action, tstate_now, bus_address, input ready);
  modport sink   (input valid, action, tstate_now, bus_address, output ready);
endinterface

interface dbcd_out_if;
  logic                          valid;
  logic                          ready;
  logic [dbcd_pkg::WAIT_W-1:0]   wait_states;

  modport source (output valid, wait_states, input ready);
  modport sink   (input valid, wait_states, output ready);
endinterface
`default_nettype wire

// File: src/dbcd_front.sv
// Front end: accepts access words and turns each into a sampling plan.
// Depends on dbcd_pkg and dbcd_in_if.
`default_nettype none
module dbcd_front (
  dbcd_in_if.sink          in_i,
  input  logic             full_i,
  output logic             push_o,
  output dbcd_pkg::plan_t  plan_o
);

  logic in_bank;
  logic a0;

  assign in_bank   = (in_i.bus_address & dbcd_pkg::BANK_MASK) == dbcd_pkg::BANK_BASE;
  assign a0        = in_i.bus_address[0];
  assign in_i.ready = !full_i;
  assign push_o    = in_i.valid && !full_i;

  // all advances of an I/O sequence sum to the base four, so only the
  // sample points matter: count and start offset
  always_comb begin
    plan_o.t0     = in_i.tstate_now;
    plan_o.nsteps = '0;
    if (in_i.action == dbcd_pkg::ACT_MEM) begin
      plan_o.nsteps = in_bank ? dbcd_pkg::STEP_W'(1) : '0;
    end else if (in_bank) begin
      plan_o.nsteps = a0 ? dbcd_pkg::STEP_W'(4) : dbcd_pkg::STEP_W'(2);
    end else if (!a0) begin
      plan_o.nsteps = dbcd_pkg::STEP_W'(1);
      plan_o.t0     = in_i.tstate_now + dbcd_pkg::TS_W'(1);
    end
  end

endmodule
`default_nettype wire

// File: src/dbcd_fifo.sv
// Short plan queue between front and back end.
// Depends on dbcd_pkg for the plan type.
`default_nettype none
module dbcd_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  dbcd_pkg::plan_t  data_i,
  output logic             full_o,
  input  logic             pop_i,
  output dbcd_pkg::plan_t  data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  dbcd_pkg::plan_t   slot_q [DEPTH];
  logic [PTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  assign full_o  = cnt_q == CNT_FULL;
  assign empty_o = cnt_q == '0;
  assign data_o  = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_LAST) ? '0 : wr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PTR_LAST) ? '0 : rd_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// File: src/dbcd_raw.sv
// Raw contention delay at one T-state: frame modulo, line divide, column.
// Depends on dbcd_pkg; radix-16 restoring divider shared by both divides.
`default_nettype none
module dbcd_raw (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dbcd_pkg::cfg_t     cfg_i,
  input  dbcd_pkg::raw_req_t req_i,
  output dbcd_pkg::raw_rsp_t rsp_o
);

  localparam int unsigned TS_W  = dbcd_pkg::TS_W;
  localparam int unsigned FL_W  = dbcd_pkg::FL_W;

  dbcd_pkg::raw_state_e state_q, state_d;

  logic [TS_W-1:0]                sh_q, sh_d;      // dividend in, quotient out
  logic [FL_W-1:0]                rem_q, rem_d;
  logic [FL_W-1:0]                div_q, div_d;
  logic [FL_W-1:0]                pos_q, pos_d;    // offset from contention start
  logic [dbcd_pkg::PROD_W-1:0]    prod_q, prod_d;
  logic [dbcd_pkg::RAW_W-1:0]     delay_q, delay_d;
  logic [dbcd_pkg::CNT_W-1:0]     cnt_q, cnt_d;

  logic [TS_W-1:0]                sh_step;
  logic [FL_W-1:0]                rem_step;
  logic [FL_W-1:0]                pos_w;
  logic [dbcd_pkg::NL_W-1:0]      last_line;
  logic [dbcd_pkg::NL_W-1:0]      line_w;
  logic [dbcd_pkg::PROD_W-1:0]    col_ext;
  logic [FL_W-1:0]                col_w;
  logic                           no_frame;

  assign no_frame  = (cfg_i.frame_length == '0) || (cfg_i.display_line_count == '0);
  assign last_line = cfg_i.display_line_count - dbcd_pkg::NL_W'(1);
  assign pos_w     = rem_q - cfg_i.contention_start;

  // four restoring steps per cycle
  always_comb begin
    logic [FL_W:0]   r_ext;
    logic [FL_W-1:0] rem_v;
    logic [TS_W-1:0] sh_v;
    logic            ge;
    rem_v = rem_q;
    sh_v  = sh_q;
    for (int i = 0; i < dbcd_pkg::RADIX; i++) begin
      r_ext = {rem_v, sh_v[TS_W-1]};
      ge    = r_ext >= {1'b0, div_q};
      sh_v  = {sh_v[TS_W-2:0], ge};
      rem_v = ge ? FL_W'(r_ext - {1'b0, div_q}) : r_ext[FL_W-1:0];
    end
    sh_step  = sh_v;
    rem_step = rem_v;
  end

  // clamp the quotient to the last display line
  assign line_w = (sh_q[dbcd_pkg::DIV_BITS-1:0] >
                   {{(dbcd_pkg::DIV_BITS - dbcd_pkg::NL_W){1'b0}}, last_line})
                  ? last_line : sh_q[dbcd_pkg::NL_W-1:0];

  assign col_ext = {{(dbcd_pkg::PROD_W - FL_W){1'b0}}, pos_q} - prod_q;
  assign col_w   = col_ext[FL_W-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dbcd_pkg::RAW_IDLE: begin
        if (req_i.start) begin
          state_d = no_frame ? dbcd_pkg::RAW_DONE : dbcd_pkg::RAW_MOD;
        end
      end
      dbcd_pkg::RAW_MOD: begin
        if (cnt_q == dbcd_pkg::MOD_LAST) begin
          state_d = dbcd_pkg::RAW_POS;
        end
      end
      dbcd_pkg::RAW_POS: begin
        if (rem_q < cfg_i.contention_start) begin
          state_d = dbcd_pkg::RAW_DONE;
        end else if (cfg_i.line_len == '0) begin
          state_d = dbcd_pkg::RAW_MUL;
        end else begin
          state_d = dbcd_pkg::RAW_DIV;
        end
      end
      dbcd_pkg::RAW_DIV: begin
        if (cnt_q == dbcd_pkg::DIV_LAST) begin
          state_d = dbcd_pkg::RAW_MUL;
        end
      end
      dbcd_pkg::RAW_MUL:  state_d = dbcd_pkg::RAW_COL;
      dbcd_pkg::RAW_COL:  state_d = dbcd_pkg::RAW_DONE;
      dbcd_pkg::RAW_DONE: state_d = dbcd_pkg::RAW_IDLE;
      default:            state_d = dbcd_pkg::RAW_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    sh_d    = sh_q;
    rem_d   = rem_q;
    div_d   = div_q;
    pos_d   = pos_q;
    prod_d  = prod_q;
    delay_d = delay_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      dbcd_pkg::RAW_IDLE: begin
        sh_d    = req_i.tnow;
        rem_d   = '0;
        div_d   = cfg_i.frame_length;
        cnt_d   = '0;
        delay_d = '0;
      end
      dbcd_pkg::RAW_MOD, dbcd_pkg::RAW_DIV: begin
        sh_d  = sh_step;
        rem_d = rem_step;
        cnt_d = cnt_q + dbcd_pkg::CNT_W'(1);
      end
      dbcd_pkg::RAW_POS: begin
        pos_d   = pos_w;
        rem_d   = '0;
        cnt_d   = '0;
        delay_d = '0;
        div_d   = {{(FL_W - dbcd_pkg::LL_W){1'b0}}, cfg_i.line_len};
        if (cfg_i.line_len == '0) begin
          // all lines start together: the last one decides
          sh_d = {{(TS_W - dbcd_pkg::NL_W){1'b0}}, last_line};
        end else begin
          sh_d = {{(dbcd_pkg::DIV_BITS - FL_W){1'b0}}, pos_w,
                  {(TS_W - dbcd_pkg::DIV_BITS){1'b0}}};
        end
      end
      dbcd_pkg::RAW_MUL: begin
        prod_d = {{dbcd_pkg::LL_W{1'b0}}, line_w} *
                 {{dbcd_pkg::NL_W{1'b0}}, cfg_i.line_len};
      end
      dbcd_pkg::RAW_COL: begin
        delay_d = (col_w < {{(FL_W - dbcd_pkg::DW_W){1'b0}}, cfg_i.display_width})
                  ? dbcd_pkg::STALL_PATTERN[col_w[dbcd_pkg::PAT_IDX_W-1:0]] : '0;
      end
      default: begin
      end
    endcase
  end

  // outputs
  always_comb begin
    rsp_o.done  = state_q == dbcd_pkg::RAW_DONE;
    rsp_o.delay = delay_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dbcd_pkg::RAW_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q    <= sh_d;
    rem_q   <= rem_d;
    div_q   <= div_d;
    pos_q   <= pos_d;
    prod_q  <= prod_d;
    delay_q <= delay_d;
  end

endmodule
`default_nettype wire

// File: src/dbcd_back.sv
// Back end: walks each plan's sample points through the raw delay unit
// and sums the delays. Depends on dbcd_pkg, dbcd_out_if and dbcd_raw.
`default_nettype none
`include "display_bus_contention_delay_macros.svh"
module dbcd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dbcd_pkg::cfg_t   cfg_i,
  input  logic             empty_i,
  input  dbcd_pkg::plan_t  plan_i,
  output logic             pop_o,
  dbcd_out_if.source       out_o
);

  dbcd_pkg::back_state_e         state_q, state_d;
  logic [dbcd_pkg::TS_W-1:0]     now_q, now_d;
  logic [dbcd_pkg::STEP_W-1:0]   left_q, left_d;
  logic [dbcd_pkg::WAIT_W-1:0]   acc_q, acc_d;
  dbcd_pkg::raw_req_t            req;
  dbcd_pkg::raw_rsp_t            rsp;

  dbcd_raw u_raw (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dbcd_pkg::BK_IDLE: begin
        if (!empty_i) begin
          state_d = (plan_i.nsteps == '0) ? dbcd_pkg::BK_OUT : dbcd_pkg::BK_REQ;
        end
      end
      dbcd_pkg::BK_REQ: state_d = dbcd_pkg::BK_WAIT;
      dbcd_pkg::BK_WAIT: begin
        if (rsp.done) begin
          state_d = (left_q == dbcd_pkg::STEP_W'(1)) ? dbcd_pkg::BK_OUT
                                                     : dbcd_pkg::BK_REQ;
        end
      end
      dbcd_pkg::BK_OUT: begin
        if (out_o.ready) begin
          state_d = dbcd_pkg::BK_IDLE;
        end
      end
      default: state_d = dbcd_pkg::BK_IDLE;
    endcase
  end

  // datapath: each contend step advances time by its delay plus one
  always_comb begin
    now_d  = now_q;
    left_d = left_q;
    acc_d  = acc_q;
    if (state_q == dbcd_pkg::BK_IDLE) begin
      now_d  = plan_i.t0;
      left_d = plan_i.nsteps;
      acc_d  = '0;
    end else if (state_q == dbcd_pkg::BK_WAIT && rsp.done) begin
      now_d  = now_q + dbcd_pkg::TS_W'(rsp.delay) + dbcd_pkg::TS_W'(1);
      left_d = left_q - dbcd_pkg::STEP_W'(1);
      acc_d  = acc_q + dbcd_pkg::WAIT_W'(rsp.delay);
    end
  end

  // outputs
  always_comb begin
    pop_o             = (state_q == dbcd_pkg::BK_IDLE) && !empty_i;
    req.start         = state_q == dbcd_pkg::BK_REQ;
    req.tnow          = now_q;
    out_o.valid       = state_q == dbcd_pkg::BK_OUT;
    out_o.wait_states = acc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dbcd_pkg::BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q  <= now_d;
    left_q <= left_d;
    acc_q  <= acc_d;
  end

  `DBCD_ASSERT(a_pop_nonempty, clk_i, rst_ni, pop_o |-> !empty_i, "pop from empty queue")
  `DBCD_ASSERT(a_done_waited, clk_i, rst_ni, rsp.done |-> state_q == dbcd_pkg::BK_WAIT, "raw done while not waiting")
  `DBCD_ASSERT_NEVER(a_no_empty_walk, clk_i, rst_ni, (state_q == dbcd_pkg::BK_REQ || state_q == dbcd_pkg::BK_WAIT) && left_q == '0, "walk with no steps left")
  `DBCD_ASSERT(a_wait_bound, clk_i, rst_ni, out_o.valid |-> acc_q <= dbcd_pkg::MAX_WAIT, "wait states above bound")
  `DBCD_ASSERT(a_out_release, clk_i, rst_ni, (out_o.valid && out_o.ready) |=> state_q == dbcd_pkg::BK_IDLE, "result held after handshake")

endmodule
`default_nettype wire

// File: src/display_bus_contention_delay.sv
// Contention delay: one delay word (0..24 wait states) per access word.
// Words with no sampled T-state go straight to the result; else each sample (at most
// one for memory, up to four for I/O) runs frame modulo, position check, line divide,
// multiply and column lookup, shorter when the frame is empty, the line length is zero or
// the T-state lies before the contention start. One word in flight in the back end; the
// queue takes new words while a result waits. Reset: config to defaults, queue empty, ends idle.
`default_nettype none
module display_bus_contention_delay #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  dbcd_in_if.sink                             in_i,
  dbcd_out_if.source                          out_o,
  input  logic                                cfg_we_i,
  input  logic [dbcd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [dbcd_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  dbcd_pkg::cfg_t   cfg_q;
  dbcd_pkg::plan_t  push_plan;
  dbcd_pkg::plan_t  pop_plan;
  logic             push;
  logic             pop;
  logic             full;
  logic             empty;

  // config registers; the user must see that they are written only while the block
  // is idle (the block does not enforce it), so the back end reads them directly
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.contention_start   <= dbcd_pkg::RST_CONT_START;
      cfg_q.line_len           <= dbcd_pkg::RST_LINE_LEN;
      cfg_q.display_line_count <= dbcd_pkg::RST_LINE_COUNT;
      cfg_q.display_width      <= dbcd_pkg::RST_DISP_WIDTH;
      cfg_q.frame_length       <= dbcd_pkg::RST_FRAME_LEN;
    end else if (cfg_we_i) begin
      unique case (dbcd_pkg::cfg_reg_e'(cfg_idx_i))
        dbcd_pkg::REG_CONT_START:
          cfg_q.contention_start   <= cfg_data_i[dbcd_pkg::CS_W-1:0];
        dbcd_pkg::REG_LINE_LEN:
          cfg_q.line_len           <= cfg_data_i[dbcd_pkg::LL_W-1:0];
        dbcd_pkg::REG_LINE_COUNT:
          cfg_q.display_line_count <= cfg_data_i[dbcd_pkg::NL_W-1:0];
        dbcd_pkg::REG_DISP_WIDTH:
          cfg_q.display_width      <= cfg_data_i[dbcd_pkg::DW_W-1:0];
        dbcd_pkg::REG_FRAME_LEN:
          cfg_q.frame_length       <= cfg_data_i[dbcd_pkg::FL_W-1:0];
        default: begin
          // unmapped index: ignored
        end
      endcase
    end
  end

  // front end: classify the access into sample count and first T-state
  dbcd_front u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .plan_o (push_plan)
  );

  // plan queue decouples acceptance from the multi-cycle back end
  dbcd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_plan),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (pop_plan),
    .empty_o (empty)
  );

  // back end: sequence raw delay evaluations, hold the result word
  dbcd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .empty_i (empty),
    .plan_i  (pop_plan),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
`default_nettype wire
